@@ rtl/core/k_nearest_neighbour_select_top_macros.svh @@
// Assertion macros shared by the k-nearest-neighbour select RTL.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef K_NEAREST_NEIGHBOUR_SELECT_TOP_MACROS_SVH
`define K_NEAREST_NEIGHBOUR_SELECT_TOP_MACROS_SVH

// Checked on every clock edge outside reset.
`define KNS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define KNS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/kns_pkg.sv @@
// Package for the k-nearest-neighbour select block: field widths, codes, defaults.
// No dependencies.
package kns_pkg;

    // Field widths fixed by the stream formats
    localparam int COORD_BITS = 12;
    localparam int IDX_W      = 8;
    localparam int DIST_W     = COORD_BITS + 1;
    localparam int RANK_W     = 3;
    localparam int IN_DATA_W  = IDX_W + 4 * COORD_BITS;
    localparam int OUT_DATA_W = IDX_W + DIST_W + RANK_W;

    // Configuration registers
    localparam int PCOUNT_W = 9;
    localparam int NCOUNT_W = 4;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOUR_COUNT = 1'd1;
    localparam logic [NCOUNT_W-1:0]  NCOUNT_RESET        = 4'd8;

    // Request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Results per query never exceed this
    localparam int RESULT_LIMIT = 8;

    // Parameter defaults
    localparam int DEF_MAX_POINTS     = 256;
    localparam int DEF_MAX_NEIGHBOURS = 8;

endpackage

@@ rtl/core/kns_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kns_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/k_nearest_neighbour_select_top.sv @@
// Top level of the k-nearest-neighbour select block: centre store, distance
// sequencer, sorted neighbour list and result register.
// Depends on kns_pkg, kns_ram and k_nearest_neighbour_select_top_macros.svh.
//
//  channel  | dir | handshake                   | payload
//  ---------+-----+-----------------------------+-------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready | tdata: index, min x/y, max x/y; tuser
//  m_axis   | out | m_axis_tvalid/m_axis_tready | tdata: index, distance, rank; tuser, tlast
//  cfg      | in  | cfg_we                      | cfg_index, cfg_data
//
// A query visits each other point below point_count in turn: difference, squares
// on the one multiplier, bit-serial square root (13 steps), both shared by all
// points, then insertion; results leave one per cycle while m_axis_tready is high.
// Reset clears control state only; the centre store is not cleared.
// s_axis_tready is high only when idle; the last result may still wait in the
// output register while the next request is accepted.
module k_nearest_neighbour_select_top
    import kns_pkg::*;
#(
    parameter int MAX_POINTS     = DEF_MAX_POINTS,
    parameter int MAX_NEIGHBOURS = DEF_MAX_NEIGHBOURS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] point_index, [19:8] box_min_x, [31:20] box_min_y,
    // [43:32] box_max_x, [55:44] box_max_y
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] req_type
    input  logic                  s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] neighbour_index, [20:8] neighbour_distance, [23:21] rank
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [0] found
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int AW      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int SCAN_W  = (CNT_W > PCOUNT_W) ? CNT_W : PCOUNT_W;
    localparam int LIST_N  = (MAX_NEIGHBOURS < RESULT_LIMIT) ? MAX_NEIGHBOURS : RESULT_LIMIT;
    localparam int FILL_W  = $clog2(LIST_N + 1);
    localparam int LIDX_W  = (LIST_N > 1) ? $clog2(LIST_N) : 1;
    localparam int RT_W    = DIST_W;
    localparam int RAD_W   = 2 * RT_W;
    localparam int REM_W   = RT_W + 1;
    localparam int STEP_W  = $clog2(RT_W);
    localparam int CW      = COORD_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QCAP,
        ST_SCAN,
        ST_DIFF,
        ST_SQX,
        ST_SQY,
        ST_ROOT,
        ST_INSERT,
        ST_EMIT
    } state_t;

    // ---------------------------------------------------------------- request fields
    logic [IDX_W-1:0] in_index;
    logic [CW-1:0]    in_min_x, in_min_y, in_max_x, in_max_y;
    logic [SCAN_W-1:0] in_index_ext;
    logic             in_index_ok;
    logic             in_accept;

    assign in_index  = s_axis_tdata[IDX_W-1:0];
    assign in_min_x  = s_axis_tdata[IDX_W +: CW];
    assign in_min_y  = s_axis_tdata[IDX_W + CW +: CW];
    assign in_max_x  = s_axis_tdata[IDX_W + 2*CW +: CW];
    assign in_max_y  = s_axis_tdata[IDX_W + 3*CW +: CW];
    assign in_index_ext = SCAN_W'(in_index);
    assign in_index_ok  = (in_index_ext < SCAN_W'(MAX_POINTS));

    // ---------------------------------------------------------------- registers
    state_t              state_reg, state_next;
    logic [PCOUNT_W-1:0] point_count_reg;
    logic [NCOUNT_W-1:0] neighbour_count_reg;
    logic [SCAN_W-1:0]   pi_reg, pi_next;
    logic [SCAN_W-1:0]   cnt_reg, cnt_next;
    logic [SCAN_W-1:0]   j_reg, j_next;
    logic [FILL_W-1:0]   n_reg, n_next;
    logic [FILL_W-1:0]   best_fill_reg, best_fill_next;
    logic [FILL_W-1:0]   e_reg, e_next;
    logic [CW-1:0]       xi_reg, xi_next, yi_reg, yi_next;
    logic [CW-1:0]       dx_reg, dx_next, dy_reg, dy_next;
    logic [RAD_W-1:0]    acc_reg, acc_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [RT_W-1:0]     root_reg, root_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [IDX_W-1:0]    best_idx_reg  [LIST_N];
    logic [IDX_W-1:0]    best_idx_next [LIST_N];
    logic [DIST_W-1:0]   best_dist_reg  [LIST_N];
    logic [DIST_W-1:0]   best_dist_next [LIST_N];
    logic                out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]    out_idx_reg, out_idx_next;
    logic [DIST_W-1:0]   out_dist_reg, out_dist_next;
    logic [RANK_W-1:0]   out_rank_reg, out_rank_next;
    logic                out_found_reg, out_found_next;
    logic                out_last_reg, out_last_next;

    // ---------------------------------------------------------------- centre store
    logic              ram_we;
    logic [AW-1:0]     ram_raddr;
    logic [2*CW-1:0]   ram_wdata, ram_rdata;
    logic [CW:0]       sum_x, sum_y;
    logic [CW-1:0]     rd_x, rd_y;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign sum_x     = {1'b0, in_min_x} + {1'b0, in_max_x};
    assign sum_y     = {1'b0, in_min_y} + {1'b0, in_max_y};
    assign ram_wdata = {sum_y[CW:1], sum_x[CW:1]};
    assign ram_we    = in_accept && (s_axis_tuser == REQ_LOAD) && in_index_ok;
    // idle: look up the queried point; scanning: look up point j
    assign ram_raddr = (state_reg == ST_IDLE) ? in_index_ext[AW-1:0] : j_reg[AW-1:0];
    assign rd_x      = ram_rdata[CW-1:0];
    assign rd_y      = ram_rdata[2*CW-1:CW];

    kns_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_POINTS)
    ) u_centre_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_index_ext[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- shared multiplier
    logic [CW-1:0]   sq_in;
    logic [2*CW-1:0] sq_out;

    assign sq_in  = (state_reg == ST_SQX) ? dx_reg : dy_reg;
    assign sq_out = sq_in * sq_in;

    // ---------------------------------------------------------------- square root step
    // one result bit per cycle: bring down two radicand bits, try root*4+1
    logic [REM_W+1:0] rt_rem;
    logic [REM_W+1:0] rt_trial;
    logic             rt_fit;

    assign rt_rem   = {rem_reg, acc_reg[RAD_W-1 -: 2]};
    assign rt_trial = (REM_W + 2)'({root_reg, 2'b01});
    assign rt_fit   = (rt_rem >= rt_trial);

    // ---------------------------------------------------------------- list insertion
    // strict-less: the new point lands before the first entry it beats, so ties
    // keep the lower index ahead
    logic [LIST_N-1:0] ins_hit;
    logic [LIDX_W-1:0] ins_pos;
    logic              ins_any;

    always_comb
    begin
        for (int k = 0; k < LIST_N; k++)
        begin
            ins_hit[k] = (FILL_W'(k) < n_reg) &&
                         ((FILL_W'(k) >= best_fill_reg) || (root_reg < best_dist_reg[k]));
        end
        ins_any = |ins_hit;
        ins_pos = '0;
        for (int k = LIST_N - 1; k >= 0; k--)
        begin
            if (ins_hit[k])
            begin
                ins_pos = LIDX_W'(k);
            end
        end
    end

    // ---------------------------------------------------------------- sequencer
    logic              out_free;
    logic [LIDX_W-1:0] e_idx;
    logic [NCOUNT_W-1:0] n_clamped;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign e_idx    = e_reg[LIDX_W-1:0];
    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        if (neighbour_count_reg == '0)
        begin
            n_clamped = NCOUNT_W'(1);
        end
        else if (neighbour_count_reg > NCOUNT_W'(LIST_N))
        begin
            n_clamped = NCOUNT_W'(LIST_N);
        end
        else
        begin
            n_clamped = neighbour_count_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pi_next        = pi_reg;
        cnt_next       = cnt_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        best_fill_next = best_fill_reg;
        e_next         = e_reg;
        xi_next        = xi_reg;
        yi_next        = yi_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        step_next      = step_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_dist_next  = out_dist_reg;
        out_rank_next  = out_rank_reg;
        out_found_next = out_found_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (s_axis_tuser == REQ_QUERY))
                begin
                    pi_next        = in_index_ext;
                    n_next         = FILL_W'(n_clamped);
                    best_fill_next = '0;
                    e_next         = '0;
                    j_next         = '0;
                    cnt_next       = (SCAN_W'(point_count_reg) > SCAN_W'(MAX_POINTS)) ?
                                     SCAN_W'(MAX_POINTS) : SCAN_W'(point_count_reg);
                    state_next     = in_index_ok ? ST_QCAP : ST_EMIT;
                end
            end
            ST_QCAP:
            begin
                xi_next    = rd_x;
                yi_next    = rd_y;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (j_reg >= cnt_reg)
                begin
                    state_next = ST_EMIT;
                end
                else if (j_reg == pi_reg)
                begin
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                dx_next    = (xi_reg > rd_x) ? (xi_reg - rd_x) : (rd_x - xi_reg);
                dy_next    = (yi_reg > rd_y) ? (yi_reg - rd_y) : (rd_y - yi_reg);
                state_next = ST_SQX;
            end
            ST_SQX:
            begin
                acc_next   = RAD_W'(sq_out);
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                acc_next   = acc_reg + RAD_W'(sq_out);
                rem_next   = '0;
                root_next  = '0;
                step_next  = STEP_W'(RT_W - 1);
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (rt_fit)
                begin
                    rem_next  = REM_W'(rt_rem - rt_trial);
                    root_next = {root_reg[RT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = REM_W'(rt_rem);
                    root_next = {root_reg[RT_W-2:0], 1'b0};
                end
                acc_next  = {acc_reg[RAD_W-3:0], 2'b00};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                if (ins_any)
                begin
                    for (int m = 0; m < LIST_N; m++)
                    begin
                        if (LIDX_W'(m) == ins_pos)
                        begin
                            best_idx_next[m]  = j_reg[IDX_W-1:0];
                            best_dist_next[m] = root_reg;
                        end
                        else if ((m > 0) && (LIDX_W'(m) > ins_pos))
                        begin
                            best_idx_next[m]  = best_idx_reg[(m > 0) ? m - 1 : 0];
                            best_dist_next[m] = best_dist_reg[(m > 0) ? m - 1 : 0];
                        end
                    end
                    if (best_fill_reg < n_reg)
                    begin
                        best_fill_next = best_fill_reg + 1'b1;
                    end
                end
                j_next     = j_reg + 1'b1;
                state_next = ST_SCAN;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (best_fill_reg == '0)
                    begin
                        // nobody to report
                        out_idx_next   = '0;
                        out_dist_next  = '0;
                        out_rank_next  = '0;
                        out_found_next = 1'b0;
                        out_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        out_idx_next   = best_idx_reg[e_idx];
                        out_dist_next  = best_dist_reg[e_idx];
                        out_rank_next  = RANK_W'(e_reg);
                        out_found_next = 1'b1;
                        out_last_next  = (e_reg + 1'b1 == best_fill_reg);
                        e_next         = e_reg + 1'b1;
                        if (e_reg + 1'b1 == best_fill_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            point_count_reg     <= '0;
            neighbour_count_reg <= NCOUNT_RESET;
            n_reg               <= FILL_W'(1);
            best_fill_reg       <= '0;
            e_reg               <= '0;
            j_reg               <= '0;
            step_reg            <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            best_fill_reg <= best_fill_next;
            e_reg         <= e_next;
            j_reg         <= j_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_POINT_COUNT:     point_count_reg     <= cfg_data[PCOUNT_W-1:0];
                    REG_NEIGHBOUR_COUNT: neighbour_count_reg <= cfg_data[NCOUNT_W-1:0];
                    default:             ;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        pi_reg        <= pi_next;
        cnt_reg       <= cnt_next;
        xi_reg        <= xi_next;
        yi_reg        <= yi_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
        out_idx_reg   <= out_idx_next;
        out_dist_reg  <= out_dist_next;
        out_rank_reg  <= out_rank_next;
        out_found_reg <= out_found_next;
        out_last_reg  <= out_last_next;
    end

    // ---------------------------------------------------------------- result port
    // distances never exceed the field: the root has exactly DIST_W bits
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_rank_reg, out_dist_reg, out_idx_reg};
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tlast  = out_last_reg;

    // ---------------------------------------------------------------- assertions
`include "k_nearest_neighbour_select_top_macros.svh"

    `KNS_ASSERT(a_fill_bound, best_fill_reg <= n_reg, "neighbour list overfilled")
    `KNS_ASSERT(a_empty_is_last, (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast, "empty result not last")
    `KNS_ASSERT(a_rank_steps, (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && (out_rank_reg == $past(out_rank_reg) + 3'd1)), "rank did not advance")
    `KNS_ASSERT(a_dist_sorted, (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (out_dist_reg >= $past(out_dist_reg)), "results out of distance order")
    `KNS_ASSERT_RST(a_reset_quiet, !rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule
